[src/tcos_pkg.sv]
`timescale 1ns / 1ps

package tcos_pkg;

    // Field widths
    localparam int ANGLE_W = 16;
    localparam int TOL_W   = 14;
    localparam int COS_W   = 16;
    localparam int TERMS_W = 3;

    // Working formats: angle magnitude Q.28, x^2 and terms Q.20
    localparam int WORK_FRAC = 20;
    localparam int XQ_FRAC   = 28;
    localparam int XQ_W      = 32;
    localparam int X2_W      = 28;
    localparam int X2_SHIFT  = 2 * XQ_FRAC - WORK_FRAC;
    localparam int RAD_SHIFT = XQ_FRAC - 13;
    localparam int MAG_W     = 33;
    localparam int PROD_W    = MAG_W + X2_W;
    localparam int N_W       = PROD_W + 1 - WORK_FRAC;
    localparam int SUM_W     = 37;
    localparam int CNT_W     = 4;
    // tolerance scaled up by at most 10 bits (smallest fraction width)
    localparam int THR_W     = TOL_W + 10;

    localparam logic [16:0]        DEG_TO_RAD_Q28 = 17'd73204;
    localparam logic [TOL_W-1:0]   TOL_RESET      = 14'd1638;
    localparam logic [MAG_W-1:0]   MAG_ONE        = MAG_W'(64'd1 << WORK_FRAC);
    localparam logic [N_W-1:0]     MAG_CAP        = N_W'(64'd1 << 32);
    localparam logic [TERMS_W-1:0] TERMS_MAX      = 3'd7;
    localparam int                 COS_POS_MAX    = 32767;
    localparam int                 COS_NEG_MAX    = 32768;

    typedef enum logic [1:0] {
        STATUS_CONV  = 2'd0,
        STATUS_LIMIT = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      in_degrees;
    } in_req_t;

    typedef struct packed {
        logic signed [COS_W-1:0] cosine;
        logic [TERMS_W-1:0]      terms_used;
        status_t                 status;
    } res_t;

    // Per-item context carried along the term pipeline
    typedef struct packed {
        logic [X2_W-1:0]         x2;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        cnt;
        logic                    done;
    } term_ctx_t;

endpackage

[src/tcos_term.sv]
`timescale 1ns / 1ps

// One series term: adds term K to the running sum, checks the change
// against the threshold, and, when NEXT is set, builds the magnitude of term K+1.
module tcos_term
    import tcos_pkg::*;
#(
    parameter int K    = 0,
    parameter bit NEXT = 1'b1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [THR_W-1:0]  thr,
    input  logic              in_vld,
    input  term_ctx_t         in_ctx,
    input  logic [MAG_W-1:0]  in_mag,
    output logic              out_vld,
    output term_ctx_t         out_ctx,
    output logic [MAG_W-1:0]  out_mag
);

    localparam int NST = NEXT ? 6 : 3;
    localparam bit ODD = (K % 2) == 1;

    logic [NST-1:0]          vld_reg;
    term_ctx_t               ctx_reg  [NST];
    term_ctx_t               ctx_next [NST];
    logic signed [SUM_W-1:0] prev_reg;
    logic [SUM_W-1:0]        a_reg;
    logic [SUM_W-1:0]        b_reg;
    logic signed [SUM_W-1:0] term_val;
    logic [SUM_W-1:0]        a_next;
    logic [SUM_W-1:0]        b_next;
    logic [SUM_W:0]          dlt;
    logic [SUM_W-1:0]        diff;
    logic                    conv;

    // Sum update, absolute values, convergence test
    always_comb begin
        term_val = $signed({{(SUM_W - MAG_W){1'b0}}, in_mag});
        ctx_next[0] = in_ctx;
        if (!in_ctx.done) begin
            ctx_next[0].sum = ODD ? in_ctx.sum - term_val : in_ctx.sum + term_val;
            ctx_next[0].cnt = in_ctx.cnt + CNT_W'(1);
        end

        a_next = ctx_reg[0].sum[SUM_W-1] ? SUM_W'(-ctx_reg[0].sum) : SUM_W'(ctx_reg[0].sum);
        b_next = prev_reg[SUM_W-1] ? SUM_W'(-prev_reg) : SUM_W'(prev_reg);
        ctx_next[1] = ctx_reg[0];

        dlt  = {1'b0, a_reg} - {1'b0, b_reg};
        diff = dlt[SUM_W] ? SUM_W'(-dlt) : dlt[SUM_W-1:0];
        conv = diff < SUM_W'(thr);
        ctx_next[2] = ctx_reg[1];
        ctx_next[2].done = ctx_reg[1].done | conv;

        for (int i = 3; i < NST; i++) begin
            ctx_next[i] = ctx_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg  <= ctx_next;
            prev_reg <= in_ctx.sum;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    assign out_vld = vld_reg[NST-1];
    assign out_ctx = ctx_reg[NST-1];

    generate
        if (NEXT) begin : g_next
            // next magnitude = round(round(mag * x2 / 2^20) / DIV), capped at 2^32
            localparam longint unsigned DIV = (2 * K + 1) * (2 * K + 2);
            localparam int DL    = $clog2(DIV);
            localparam int HI_W  = N_W - WORK_FRAC;
            localparam int SH    = HI_W + DL;
            localparam int MH_W  = HI_W + 2;
            localparam int M_W   = WORK_FRAC + DL;
            localparam int SL    = M_W + DL;
            localparam int ML_W  = M_W + 2;
            localparam longint unsigned MH_L = ((64'd1 << SH) + DIV - 1) / DIV;
            localparam longint unsigned ML_L = ((64'd1 << SL) + DIV - 1) / DIV;
            localparam logic [MH_W-1:0] MH    = MH_W'(MH_L);
            localparam logic [ML_W-1:0] ML    = ML_W'(ML_L);
            localparam logic [HI_W-1:0] DIV_C = HI_W'(DIV);
            localparam logic [PROD_W:0] RND_C =
                (PROD_W + 1)'((DIV / 2) * (64'd1 << WORK_FRAC) + (64'd1 << (WORK_FRAC - 1)));

            logic [PROD_W-1:0]         prod_reg;
            logic [N_W-1:0]            n_reg;
            logic [HI_W-1:0]           hi_reg;
            logic [WORK_FRAC-1:0]      lo_reg;
            logic [HI_W-1:0]           qh3_reg;
            logic [HI_W-1:0]           qh4_reg;
            logic [HI_W-1:0]           qh5_reg;
            logic [M_W-1:0]            m_reg;
            logic [WORK_FRAC-1:0]      ql_reg;
            logic [MAG_W-1:0]          mag_reg;
            logic [PROD_W:0]           rnd_sum;
            logic [HI_W+MH_W-1:0]      qh_prod;
            logic [HI_W-1:0]           qd;
            logic [HI_W-1:0]           rem;
            logic [M_W+ML_W-1:0]       ql_prod;
            logic [N_W-1:0]            quo;

            always_comb begin
                rnd_sum = {1'b0, prod_reg} + RND_C;
                // high digit by reciprocal, then remainder
                qh_prod = n_reg[N_W-1:WORK_FRAC] * MH;
                qd      = HI_W'(qh3_reg * DIV_C);
                rem     = hi_reg - qd;
                // low digit by reciprocal
                ql_prod = m_reg * ML;
                quo     = {qh5_reg, ql_reg};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg <= in_mag * in_ctx.x2;
                    n_reg    <= rnd_sum[PROD_W:WORK_FRAC];
                    qh3_reg  <= HI_W'(qh_prod >> SH);
                    hi_reg   <= n_reg[N_W-1:WORK_FRAC];
                    lo_reg   <= n_reg[WORK_FRAC-1:0];
                    qh4_reg  <= qh3_reg;
                    m_reg    <= {rem[DL-1:0], lo_reg};
                    qh5_reg  <= qh4_reg;
                    ql_reg   <= ql_prod[SL+WORK_FRAC-1:SL];
                    mag_reg  <= (quo > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : quo[MAG_W-1:0];
                end
            end

            assign out_mag = mag_reg;
        end else begin : g_none
            assign out_mag = '0;
        end
    endgenerate

endmodule

[src/taylor_cosine_until_converged.sv]
`timescale 1ns / 1ps

// Channel   Ports                              Content
// input     s_valid, s_ready, s_req            angle, in_degrees
// result    m_valid, m_ready, m_req            cosine, terms_used, status
// config    cfg_wr_en, cfg_wr_data             tolerance (no read-back)
//
// One request per cycle while the result channel is not stalled; each request
// passes through three front-end stages, six register stages per series term
// (three for the last term) and two output stages.
// Reset: synchronous, active low; clears valid bits and loads tolerance 1638.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module taylor_cosine_until_converged
    import tcos_pkg::*;
#(
    parameter int MAX_TERMS = 7,
    parameter int FRAC_BITS = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_req_t          s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output res_t             m_req,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data
);

    localparam int SHIFT = WORK_FRAC - FRAC_BITS;
    localparam logic [SUM_W:0] RND_HALF = (SUM_W + 1)'((64'd1 << SHIFT) >> 1);

    logic                en;
    logic [TOL_W-1:0]    tol_reg;
    logic [THR_W-1:0]    thr;
    logic [2:0]          vld_f_reg;
    logic [ANGLE_W-1:0]  amag_reg;
    logic                deg_reg;
    logic [XQ_W-1:0]     xq_reg;
    logic [X2_W-1:0]     x2_reg;
    logic [ANGLE_W-1:0]  amag_next;
    logic [XQ_W-1:0]     xq_next;
    logic [2*XQ_W:0]     sq_rnd;

    logic                vld_bus [MAX_TERMS+1];
    term_ctx_t           ctx_bus [MAX_TERMS+1];
    logic [MAG_W-1:0]    mag_bus [MAX_TERMS+1];

    logic                vld_o_reg;
    logic [SUM_W-1:0]    abs_reg;
    logic                neg_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    abs_next;
    logic [SUM_W:0]      u_rnd;
    logic [SUM_W:0]      u_val;
    res_t                res_next;
    logic                m_valid_reg;
    res_t                m_req_reg;

    // Global advance: move when the output register is free or taken
    assign en      = m_ready | ~m_valid_reg;
    assign s_ready = en;

    // Tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    assign thr = THR_W'(tol_reg) << SHIFT;

    // Front end: |angle|, Q.28 radians, x^2 in Q.20
    always_comb begin
        amag_next = s_req.angle[ANGLE_W-1] ? ANGLE_W'(-s_req.angle) : ANGLE_W'(s_req.angle);
        xq_next   = deg_reg ? XQ_W'(amag_reg) * XQ_W'(DEG_TO_RAD_Q28)
                            : XQ_W'({amag_reg, {RAD_SHIFT{1'b0}}});
        sq_rnd    = (2 * XQ_W + 1)'(xq_reg) * (2 * XQ_W + 1)'(xq_reg)
                    + ((2 * XQ_W + 1)'(1) << (X2_SHIFT - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_f_reg <= '0;
        end else if (en) begin
            vld_f_reg <= {vld_f_reg[1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            amag_reg <= amag_next;
            deg_reg  <= s_req.in_degrees;
            xq_reg   <= xq_next;
            x2_reg   <= sq_rnd[X2_SHIFT+X2_W-1:X2_SHIFT];
        end
    end

    // Series terms, empty sum and unit first term
    assign vld_bus[0] = vld_f_reg[2];
    assign ctx_bus[0] = '{x2: x2_reg, sum: '0, cnt: '0, done: 1'b0};
    assign mag_bus[0] = MAG_ONE;

    generate
        for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
            if (k < MAX_TERMS - 1) begin : g_mid
                tcos_term #(
                    .K    (k),
                    .NEXT (1'b1)
                ) u_term (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .en      (en),
                    .thr     (thr),
                    .in_vld  (vld_bus[k]),
                    .in_ctx  (ctx_bus[k]),
                    .in_mag  (mag_bus[k]),
                    .out_vld (vld_bus[k+1]),
                    .out_ctx (ctx_bus[k+1]),
                    .out_mag (mag_bus[k+1])
                );
            end else begin : g_last
                tcos_term #(
                    .K    (k),
                    .NEXT (1'b0)
                ) u_term (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .en      (en),
                    .thr     (thr),
                    .in_vld  (vld_bus[k]),
                    .in_ctx  (ctx_bus[k]),
                    .in_mag  (mag_bus[k]),
                    .out_vld (vld_bus[k+1]),
                    .out_ctx (ctx_bus[k+1]),
                    .out_mag (mag_bus[k+1])
                );
            end
        end
    endgenerate

    // Output: magnitude, rounding to the output format, saturation
    always_comb begin
        abs_next = ctx_bus[MAX_TERMS].sum[SUM_W-1] ? SUM_W'(-ctx_bus[MAX_TERMS].sum)
                                                   : SUM_W'(ctx_bus[MAX_TERMS].sum);
        u_rnd = {1'b0, abs_reg} + RND_HALF;
        u_val = u_rnd >> SHIFT;

        res_next.status     = done_reg ? STATUS_CONV : STATUS_LIMIT;
        res_next.terms_used = (cnt_reg > CNT_W'(TERMS_MAX)) ? TERMS_MAX : cnt_reg[TERMS_W-1:0];
        if (neg_reg) begin
            if (u_val > (SUM_W + 1)'(COS_NEG_MAX)) begin
                res_next.cosine = COS_W'(-COS_NEG_MAX);
                res_next.status = STATUS_SAT;
            end else begin
                res_next.cosine = COS_W'(-u_val);
            end
        end else begin
            if (u_val > (SUM_W + 1)'(COS_POS_MAX)) begin
                res_next.cosine = COS_W'(COS_POS_MAX);
                res_next.status = STATUS_SAT;
            end else begin
                res_next.cosine = COS_W'(u_val);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_o_reg   <= vld_bus[MAX_TERMS];
            m_valid_reg <= vld_o_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            abs_reg   <= abs_next;
            neg_reg   <= ctx_bus[MAX_TERMS].sum[SUM_W-1];
            done_reg  <= ctx_bus[MAX_TERMS].done;
            cnt_reg   <= ctx_bus[MAX_TERMS].cnt;
            m_req_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_req   = m_req_reg;

endmodule

[src/tcos_chk.sv]
`timescale 1ns / 1ps

// Port-level checks on the cosine block
module tcos_chk
    import tcos_pkg::*;
#(
    parameter int MAX_TERMS = 7
) (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input res_t    m_req
);

    localparam logic [TERMS_W-1:0] TERMS_CAP =
        (MAX_TERMS > 7) ? TERMS_MAX : TERMS_W'(MAX_TERMS);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_req))
        else $error("result changed while stalled");

    // a blocked output stops intake
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input request taken while output stalled");

    // saturation shows at a range end
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_req.status == STATUS_SAT |->
            m_req.cosine == 16'sh7fff || m_req.cosine == 16'sh8000)
        else $error("saturated status with in-range cosine");

    // unconverged result used every term
    a_limit_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_req.status == STATUS_LIMIT |-> m_req.terms_used == TERMS_CAP)
        else $error("term limit status with short term count");

    // at least the first term is always added
    a_terms_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_req.terms_used != '0)
        else $error("result with zero terms");

endmodule

bind taylor_cosine_until_converged tcos_chk #(
    .MAX_TERMS (MAX_TERMS)
) u_tcos_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_req   (m_req)
);

[verif/tb_taylor_cosine_until_converged.sv]
`timescale 1ns / 1ps

module tb_taylor_cosine_until_converged;
    import tcos_pkg::*;

    localparam int N_TERMS    = 7;
    localparam int FRAC       = 14;
    localparam int LATENCY    = 6 * N_TERMS + 2;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 200;
    localparam int N_PHASES   = 6;
    localparam int PHASE_ITEMS = 150;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_req_t          s_req       = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    res_t             m_req;
    logic             cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0] cfg_wr_data = '0;

    in_req_t          angle_q[$];
    res_t             cos_expected_q[$];
    logic [TOL_W-1:0] tol_model = TOL_RESET;
    bit               quiet     = 1'b0;
    int               n_sent    = 0;
    int               n_err     = 0;
    int               cyc       = 0;
    int               src_gap   = 0;
    int               snk_gap   = 0;
    int               hold_cnt  = 0;
    bit               hold_done = 1'b0;

    taylor_cosine_until_converged #(
        .MAX_TERMS(N_TERMS),
        .FRAC_BITS(FRAC)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_req      (m_req),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Truncated Maclaurin cosine, Q.20 working sum, Q2.14 result
    function automatic res_t cosine_series(in_req_t r, logic [TOL_W-1:0] tol);
        logic [ANGLE_W-1:0] raw;
        longint unsigned    amag, xq, x2, thr, mag, a, b, diff, d, p, u;
        longint             sum, prev;
        bit                 neg, conv;
        int                 n, k, shift;
        res_t               o;
        raw   = r.angle;
        amag  = raw[ANGLE_W-1] ? (64'd65536 - 64'(raw)) : 64'(raw);
        xq    = r.in_degrees ? amag * 64'(DEG_TO_RAD_Q28) : amag << 15;
        x2    = (xq * xq + (64'd1 << 35)) >> 36;
        shift = WORK_FRAC - FRAC;
        thr   = 64'(tol) << shift;
        mag   = 64'd1 << WORK_FRAC;
        neg   = 1'b0;
        conv  = 1'b0;
        sum   = 0;
        n     = 0;
        for (k = 0; k < N_TERMS; k++) begin
            prev = sum;
            sum  = neg ? sum - longint'(mag) : sum + longint'(mag);
            n++;
            a    = (sum < 0) ? longint'(-sum) : longint'(sum);
            b    = (prev < 0) ? longint'(-prev) : longint'(prev);
            diff = (a > b) ? a - b : b - a;
            if (diff < thr) begin
                conv = 1'b1;
                break;
            end
            d   = 64'((2 * k + 1) * (2 * k + 2));
            p   = (mag * x2 + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC;
            mag = (p + d / 2) / d;
            if (mag > (64'd1 << 32))
                mag = 64'd1 << 32;
            neg = ~neg;
        end
        // round half away from zero down to the output fraction
        u = (sum < 0) ? longint'(-sum) : longint'(sum);
        if (shift > 0)
            u = (u + (64'd1 << (shift - 1))) >> shift;
        o.status = conv ? STATUS_CONV : STATUS_LIMIT;
        if (sum < 0) begin
            if (u > 64'(COS_NEG_MAX)) begin
                o.cosine = -16'sd32768;
                o.status = STATUS_SAT;
            end else begin
                o.cosine = COS_W'(-longint'(u));
            end
        end else begin
            if (u > 64'(COS_POS_MAX)) begin
                o.cosine = 16'sd32767;
                o.status = STATUS_SAT;
            end else begin
                o.cosine = COS_W'(u);
            end
        end
        o.terms_used = (n > 7) ? TERMS_MAX : TERMS_W'(n);
        return o;
    endfunction

    // Mix of full-range words and angles inside one turn
    function automatic in_req_t random_angle();
        in_req_t r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                r.angle      = ANGLE_W'($urandom);
                r.in_degrees = 1'($urandom);
            end
            4, 5, 6: begin
                r.angle      = ANGLE_W'($urandom_range(0, 2 * 25736) - 25736);
                r.in_degrees = 1'b0;
            end
            default: begin
                r.angle      = ANGLE_W'($urandom_range(0, 2 * 23040) - 23040);
                r.in_degrees = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic in_req_t mk_req(int ang, bit deg);
        in_req_t r;
        r.angle      = ANGLE_W'(ang);
        r.in_degrees = deg;
        return r;
    endfunction

    task automatic wait_drained();
        while (angle_q.size() != 0 || s_valid || cos_expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        @(negedge aclk);
        tol_model = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Request driver: random idle bursts, valid held until accepted
    always @(posedge aclk) begin : drv
        logic    nxt_valid;
        in_req_t nxt_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap  = 0;
        end else begin
            nxt_valid = s_valid;
            nxt_req   = s_req;
            if (s_valid && s_ready) begin
                cos_expected_q.push_back(cosine_series(s_req, tol_model));
                n_sent++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 8);
                end else if (angle_q.size() != 0) begin
                    nxt_req   = angle_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_valid <= nxt_valid;
            s_req   <= nxt_req;
        end
    end

    // Long receiver hold-off once, so the pipeline fills and s_ready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin : mon
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cos_expected_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: cosine %0d terms %0d status %0d",
                                 m_req.cosine, m_req.terms_used, m_req.status);
                end else begin
                    want = cos_expected_q.pop_front();
                    if (m_req.cosine !== want.cosine ||
                        m_req.terms_used !== want.terms_used ||
                        m_req.status !== want.status) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"mismatch: cosine exp %0d got %0d, terms exp %0d ",
                                      "got %0d, status exp %0d got %0d"},
                                     want.cosine, m_req.cosine, want.terms_used,
                                     m_req.terms_used, want.status, m_req.status);
                    end
                end
            end
            if (hold_cnt != 0) begin
                m_ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_CAP) begin
            $display("tb_taylor_cosine_until_converged failed");
            $finish;
        end
    end

    // Phases: reset tolerance, zero, maximum, one, then random settings
    initial begin : stim
        int i, ph;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, key angles, both units
        angle_q.push_back(mk_req(0, 1'b0));
        angle_q.push_back(mk_req(0, 1'b1));
        angle_q.push_back(mk_req(32767, 1'b0));
        angle_q.push_back(mk_req(-32768, 1'b0));
        angle_q.push_back(mk_req(32767, 1'b1));
        angle_q.push_back(mk_req(-32768, 1'b1));
        angle_q.push_back(mk_req(1, 1'b0));
        angle_q.push_back(mk_req(-1, 1'b1));
        angle_q.push_back(mk_req(8192, 1'b0));
        angle_q.push_back(mk_req(-8192, 1'b0));
        angle_q.push_back(mk_req(12868, 1'b0));
        angle_q.push_back(mk_req(25736, 1'b0));
        angle_q.push_back(mk_req(16384, 1'b0));
        angle_q.push_back(mk_req(64, 1'b1));
        angle_q.push_back(mk_req(2880, 1'b1));
        angle_q.push_back(mk_req(5760, 1'b1));
        angle_q.push_back(mk_req(-5760, 1'b1));
        angle_q.push_back(mk_req(11520, 1'b1));
        angle_q.push_back(mk_req(23040, 1'b1));
        angle_q.push_back(mk_req(16'h5555, 1'b0));
        angle_q.push_back(mk_req(16'hAAAA, 1'b1));
        angle_q.push_back(mk_req(100, 1'b0));

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                case (ph)
                    1: write_tolerance('0);
                    2: write_tolerance(14'd16383);
                    3: write_tolerance(14'd1);
                    4: write_tolerance(TOL_W'($urandom_range(1, 400)));
                    default: write_tolerance(TOL_W'($urandom_range(1, 16383)));
                endcase
                @(negedge aclk);
            end
            if (ph == N_PHASES - 1)
                quiet = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
                angle_q.push_back(random_angle());
        end

        wait_drained();
        repeat (LATENCY + 16) @(posedge aclk);
        @(negedge aclk);
        if (n_err == 0 && cos_expected_q.size() == 0) begin
            $display("tb_taylor_cosine_until_converged passed");
        end else begin
            $display("tb_taylor_cosine_until_converged failed");
        end
        $finish;
    end

endmodule
